>>> rtl/fetp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fetp_pkg
// Types and constants shared by the escape-time pixel block: item payloads,
// configuration register set, register indices and controller commands.
// ---------------------------------------------------------------------------
package fetp_pkg;

	// Register indices on the configuration port.
	localparam logic [2:0] REG_REAL_ORIGIN = 3'd0;
	localparam logic [2:0] REG_IMAG_ORIGIN = 3'd1;
	localparam logic [2:0] REG_REAL_STEP   = 3'd2;
	localparam logic [2:0] REG_IMAG_STEP   = 3'd3;
	localparam logic [2:0] REG_JULIA_REAL  = 3'd4;
	localparam logic [2:0] REG_JULIA_IMAG  = 3'd5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int ITER_FIELD_W = 6;

	// Reset values of the configuration registers.
	localparam logic [15:0] RST_REAL_ORIGIN = 16'hE400; // -7168
	localparam logic [15:0] RST_IMAG_ORIGIN = 16'hF202; // -3582
	localparam logic [7:0]  RST_REAL_STEP   = 8'd51;
	localparam logic [7:0]  RST_IMAG_STEP   = 8'd36;
	localparam logic [15:0] RST_JULIA_REAL  = 16'h0000;
	localparam logic [15:0] RST_JULIA_IMAG  = 16'h0000;

	// Colour bands: iterations scaled by this factor over the limit.
	localparam int BAND_SCALE = 8;
	localparam logic [1:0] COLOR_INTERIOR = 2'd0;
	localparam logic [1:0] BAND_LAST      = 2'd2;

	typedef struct packed {
		logic [7:0] column;
		logic [7:0] row;
	} in_item_t;

	typedef struct packed {
		logic [ITER_FIELD_W-1:0] iterations;
		logic [1:0]              color_value;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] real_origin;
		logic signed [15:0] imag_origin;
		logic [7:0]         real_step;
		logic [7:0]         imag_step;
		logic signed [15:0] julia_real;
		logic signed [15:0] julia_imag;
	} cfg_t;

	typedef struct packed {
		logic load_coord;
		logic setup;
		logic step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic done;
	} status_t;

endpackage
`default_nettype wire

>>> rtl/fetp_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fetp_ctrl
// Controller: accepts one item, sequences setup and the iteration loop, and
// owns the output valid flag of the result register.
// ---------------------------------------------------------------------------
module fetp_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire              out_stall,
	input  wire fetp_pkg::status_t status,
	output fetp_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SETUP,
		S_ITER
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.load_coord = (state_q == S_IDLE) && in_valid;
		cmd.setup      = (state_q == S_SETUP);
		cmd.step       = (state_q == S_ITER) && !status.done;
		cmd.load_out   = (state_q == S_ITER) && status.done && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					state_q <= S_ITER;
				end
				S_ITER: begin
					// The result waits here until the output register is free.
					if (status.done && slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_accept_to_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_SETUP))
		else $error("accepted item did not start setup");

	a_setup_to_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SETUP) |=> (state_q == S_ITER))
		else $error("setup not followed by iteration");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result loaded but not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.load_out)
		else $error("pending result overwritten");

endmodule
`default_nettype wire

>>> rtl/fetp_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fetp_datapath
// Datapath: coordinate setup, one escape-time iteration per cycle in a shared
// square and cross-product unit, colour band tracking and the result register.
// ---------------------------------------------------------------------------
module fetp_datapath #(
	parameter int MAX_ITER  = 32,
	parameter int FRAC_BITS = 12
) (
	input  wire                clk,
	input  wire fetp_pkg::cfg_t     cfg,
	input  wire fetp_pkg::in_item_t in_data,
	input  wire fetp_pkg::cmd_t     cmd,
	output fetp_pkg::status_t  status,
	output fetp_pkg::out_item_t out_data
);

	localparam int IW = ($clog2(MAX_ITER + 1) > fetp_pkg::ITER_FIELD_W) ?
		$clog2(MAX_ITER + 1) : fetp_pkg::ITER_FIELD_W;
	localparam int AW = $clog2(MAX_ITER + fetp_pkg::BAND_SCALE);
	localparam logic [IW-1:0] ITER_LIMIT = IW'(MAX_ITER);
	localparam logic [AW-1:0] ACC_LIMIT  = AW'(MAX_ITER);
	localparam logic [AW-1:0] ACC_INC    = AW'(fetp_pkg::BAND_SCALE);
	localparam logic [31:0]   ESC_LIMIT  = 32'd4 << (2 * FRAC_BITS);

	logic [7:0]          col_q;
	logic [7:0]          row_q;
	logic signed [15:0]  zr_q;
	logic signed [15:0]  zi_q;
	logic signed [15:0]  cr_q;
	logic signed [15:0]  ci_q;
	logic [IW-1:0]       iter_q;
	logic [AW-1:0]       acc_q;
	logic [1:0]          band_q;
	fetp_pkg::out_item_t out_q;

	logic [15:0]         prod_r;
	logic [15:0]         prod_i;
	logic signed [15:0]  cv;
	logic signed [15:0]  cy;
	logic                julia;

	logic signed [31:0]  sq_r;
	logic signed [31:0]  sq_i;
	logic signed [31:0]  cross_p;
	logic [31:0]         mag;
	logic signed [31:0]  diff_sh;
	logic signed [31:0]  cross_sh;
	logic signed [15:0]  nzr;
	logic signed [15:0]  nzi;
	logic                escape;
	logic [AW-1:0]       acc_next;

	// Pixel coordinate, wrapped to 16 bits.
	assign prod_r = 16'(col_q) * 16'(cfg.real_step);
	assign prod_i = 16'(row_q) * 16'(cfg.imag_step);
	assign cv     = cfg.real_origin + $signed(prod_r);
	assign cy     = cfg.imag_origin + $signed(prod_i);
	assign julia  = (cfg.julia_real != 16'sd0) || (cfg.julia_imag != 16'sd0);

	// One iteration of z = z^2 + c with the escape test on exact squares.
	assign sq_r     = zr_q * zr_q;
	assign sq_i     = zi_q * zi_q;
	assign cross_p  = zr_q * zi_q;
	assign mag      = $unsigned(sq_r) + $unsigned(sq_i);
	assign escape   = (mag >= ESC_LIMIT);
	assign diff_sh  = (sq_r - sq_i) >>> FRAC_BITS;
	assign cross_sh = cross_p >>> FRAC_BITS;
	assign nzr      = $signed(diff_sh[15:0]) + cr_q;
	assign nzi      = $signed({cross_sh[14:0], 1'b0}) + ci_q;

	assign status.done = escape || (iter_q == ITER_LIMIT);
	assign acc_next    = acc_q + ACC_INC;
	assign out_data    = out_q;

	always_ff @(posedge clk) begin
		if (cmd.load_coord) begin
			col_q <= in_data.column;
			row_q <= in_data.row;
		end
		if (cmd.setup) begin
			if (julia) begin
				zr_q <= cv;
				zi_q <= cy;
				cr_q <= cfg.julia_real;
				ci_q <= cfg.julia_imag;
			end else begin
				zr_q <= 16'sd0;
				zi_q <= 16'sd0;
				cr_q <= cv;
				ci_q <= cy;
			end
			iter_q <= '0;
			acc_q  <= '0;
			band_q <= '0;
		end else if (cmd.step) begin
			zr_q   <= nzr;
			zi_q   <= nzi;
			iter_q <= iter_q + IW'(1);
			// Band is iterations * 8 / MAX_ITER, tracked modulo three.
			if (acc_next >= ACC_LIMIT) begin
				acc_q  <= acc_next - ACC_LIMIT;
				band_q <= (band_q == fetp_pkg::BAND_LAST) ? 2'd0 : band_q + 2'd1;
			end else begin
				acc_q <= acc_next;
			end
		end
		if (cmd.load_out) begin
			out_q.iterations <= iter_q[fetp_pkg::ITER_FIELD_W-1:0];
			out_q.color_value <= (iter_q == ITER_LIMIT) ? fetp_pkg::COLOR_INTERIOR :
				band_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

>>> rtl/fractal_escape_time_pixel.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fractal_escape_time_pixel
// Escape-time Mandelbrot / Julia pixel in 16-bit fixed point: holds the
// configuration registers and joins the controller to the datapath.
// ---------------------------------------------------------------------------
// Sequence: an accepted pixel passes a setup state, then its iterations and a
// final escape or limit test that loads the result register. A new item is
// taken only when the block is back in idle, and a finished result held by a
// stalled output keeps it waiting.
// Reset returns the controller to idle, clears the output valid flag and
// loads the configuration registers with their default values.
// ---------------------------------------------------------------------------
module fractal_escape_time_pixel #(
	parameter int MAX_ITER  = 32,
	parameter int FRAC_BITS = 12
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire fetp_pkg::in_item_t            in_data,
	output logic                               out_valid,
	input  wire                                out_stall,
	output fetp_pkg::out_item_t                out_data,
	input  wire                                cfg_write,
	input  wire [fetp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire [fetp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	fetp_pkg::cfg_t    cfg_q;
	fetp_pkg::cmd_t    cmd;
	fetp_pkg::status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.real_origin <= fetp_pkg::RST_REAL_ORIGIN;
			cfg_q.imag_origin <= fetp_pkg::RST_IMAG_ORIGIN;
			cfg_q.real_step   <= fetp_pkg::RST_REAL_STEP;
			cfg_q.imag_step   <= fetp_pkg::RST_IMAG_STEP;
			cfg_q.julia_real  <= fetp_pkg::RST_JULIA_REAL;
			cfg_q.julia_imag  <= fetp_pkg::RST_JULIA_IMAG;
		end else if (cfg_write) begin
			unique case (cfg_index)
				fetp_pkg::REG_REAL_ORIGIN: cfg_q.real_origin <= cfg_data;
				fetp_pkg::REG_IMAG_ORIGIN: cfg_q.imag_origin <= cfg_data;
				fetp_pkg::REG_REAL_STEP:   cfg_q.real_step   <= cfg_data[7:0];
				fetp_pkg::REG_IMAG_STEP:   cfg_q.imag_step   <= cfg_data[7:0];
				fetp_pkg::REG_JULIA_REAL:  cfg_q.julia_real  <= cfg_data;
				fetp_pkg::REG_JULIA_IMAG:  cfg_q.julia_imag  <= cfg_data;
				default: begin
					// Writes to unused indices are dropped.
				end
			endcase
		end
	end

	fetp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	fetp_datapath #(
		.MAX_ITER  (MAX_ITER),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk      (clk),
		.cfg      (cfg_q),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

>>> sim/tb_fractal_escape_time_pixel.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_fractal_escape_time_pixel
// Self-checking bench for the escape-time pixel block. Pixels are sent with
// random bursts and gaps while the result side stalls at random. Each
// accepted pixel is scored by a bit-accurate escape-time predictor, and every
// result is compared field by field with the oldest score still due.
// Mandelbrot and Julia views, register extremes and register decoding are
// covered.
// ---------------------------------------------------------------------------
module tb_fractal_escape_time_pixel;

	localparam int MAX_ITER    = 32;
	localparam int FRAC_BITS   = 12;
	localparam int COLOR_BANDS = 3;
	localparam int IDX_W       = fetp_pkg::CFG_INDEX_W;
	localparam int DATA_W      = fetp_pkg::CFG_DATA_W;
	localparam int ITER_W      = fetp_pkg::ITER_FIELD_W;
	localparam logic [32:0] ESCAPE_LIMIT = 33'd4 << (2 * FRAC_BITS);
	localparam int CYCLE_LIMIT = 500000;

	// Indices that decode to no register.
	localparam logic [IDX_W-1:0] REG_UNUSED_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_UNUSED_B = 3'd7;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	fetp_pkg::in_item_t     in_data   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	fetp_pkg::out_item_t    out_data;
	logic                   cfg_write = 1'b0;
	logic [IDX_W-1:0]       cfg_index = '0;
	logic [DATA_W-1:0]      cfg_data  = '0;

	fetp_pkg::cfg_t      pixel_view;
	fetp_pkg::out_item_t pixel_results_due[$];
	fetp_pkg::out_item_t due_item;
	int        mismatch_count = 0;
	int        cycle_count    = 0;
	int        tx_gap_max     = 0;
	int        tx_burst_left  = 0;
	int        rx_stall_max   = 0;
	bit        rx_stalling    = 1'b0;
	int        rx_left        = 0;

	fractal_escape_time_pixel #(
		.MAX_ITER (MAX_ITER),
		.FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Escape-time count and colour band of one pixel under the current view.
	function automatic fetp_pkg::out_item_t escape_time(input logic [7:0] col,
		input logic [7:0] row);
		logic [15:0]        span_r, span_i;
		logic signed [15:0] pos_r, pos_i, zr, zi, cr, ci, next_zr, twice;
		logic signed [31:0] zr_sq, zi_sq, diff, zrzi;
		logic [32:0]        mag;
		int                 n;
		fetp_pkg::out_item_t res;
		span_r = col * pixel_view.real_step;
		span_i = row * pixel_view.imag_step;
		pos_r  = pixel_view.real_origin + span_r;
		pos_i  = pixel_view.imag_origin + span_i;
		if (pixel_view.julia_real != 0 || pixel_view.julia_imag != 0) begin
			zr = pos_r;
			zi = pos_i;
			cr = pixel_view.julia_real;
			ci = pixel_view.julia_imag;
		end else begin
			zr = '0;
			zi = '0;
			cr = pos_r;
			ci = pos_i;
		end
		for (n = 0; n < MAX_ITER; n++) begin
			zr_sq = zr * zr;
			zi_sq = zi * zi;
			mag   = zr_sq + zi_sq;
			if (mag >= ESCAPE_LIMIT)
				break;
			diff    = (zr_sq - zi_sq) >>> FRAC_BITS;
			zrzi    = (zr * zi) >>> FRAC_BITS;
			next_zr = diff[15:0] + cr;
			// Doubling the truncated cross term wraps within 16 bits.
			twice   = {zrzi[14:0], 1'b0};
			zi      = twice + ci;
			zr      = next_zr;
		end
		res.iterations = ITER_W'(n);
		if (n >= MAX_ITER)
			res.color_value = fetp_pkg::COLOR_INTERIOR;
		else
			res.color_value = 2'(((n * fetp_pkg::BAND_SCALE) / MAX_ITER) % COLOR_BANDS + 1);
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $time, what);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_results_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing due: iterations %0d colour %0d",
					out_data.iterations, out_data.color_value));
			end else begin
				due_item = pixel_results_due.pop_front();
				if (out_data.iterations !== due_item.iterations)
					report_mismatch($sformatf("iterations %0d, want %0d",
						out_data.iterations, due_item.iterations));
				if (out_data.color_value !== due_item.color_value)
					report_mismatch($sformatf("colour %0d, want %0d",
						out_data.color_value, due_item.color_value));
			end
		end
	end

	// The result side alternates between stall runs and free runs of random length.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_stalling = !rx_stalling;
			rx_left = rx_stalling ? $urandom_range(1, 12) : $urandom_range(1, 25);
		end
		rx_left--;
		out_stall <= rx_stalling && (rx_stall_max != 0);
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			fetp_pkg::REG_REAL_ORIGIN: pixel_view.real_origin = val;
			fetp_pkg::REG_IMAG_ORIGIN: pixel_view.imag_origin = val;
			fetp_pkg::REG_REAL_STEP:   pixel_view.real_step   = val[7:0];
			fetp_pkg::REG_IMAG_STEP:   pixel_view.imag_step   = val[7:0];
			fetp_pkg::REG_JULIA_REAL:  pixel_view.julia_real  = val;
			fetp_pkg::REG_JULIA_IMAG:  pixel_view.julia_imag  = val;
			default: ;
		endcase
	endtask

	task automatic set_view(input logic [15:0] r_org, input logic [15:0] i_org,
		input logic [15:0] r_step, input logic [15:0] i_step,
		input logic [15:0] j_real, input logic [15:0] j_imag);
		write_reg(fetp_pkg::REG_REAL_ORIGIN, r_org);
		write_reg(fetp_pkg::REG_IMAG_ORIGIN, i_org);
		write_reg(fetp_pkg::REG_REAL_STEP, r_step);
		write_reg(fetp_pkg::REG_IMAG_STEP, i_step);
		write_reg(fetp_pkg::REG_JULIA_REAL, j_real);
		write_reg(fetp_pkg::REG_JULIA_IMAG, j_imag);
	endtask

	task automatic send_pixel(input logic [7:0] col, input logic [7:0] row);
		int gap;
		if (tx_gap_max > 0 && tx_burst_left == 0) begin
			gap = $urandom_range(1, tx_gap_max);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			tx_burst_left = $urandom_range(1, 12);
		end
		if (tx_burst_left > 0)
			tx_burst_left--;
		@(negedge clk);
		in_valid       <= 1'b1;
		in_data.column <= col;
		in_data.row    <= row;
		do @(posedge clk); while (in_stall);
		pixel_results_due.push_back(escape_time(col, row));
	endtask

	// Holds the sender off until every result due has been taken.
	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixel_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_view();
		tx_gap_max   = 3;
		rx_stall_max = 1;
		send_pixel(8'd0, 8'd0);
		send_pixel(8'd255, 8'd255);
		send_pixel(8'd159, 8'd199);
		send_pixel(8'd80, 8'd100);
		send_pixel(8'hAA, 8'h55);
		send_pixel(8'h55, 8'hAA);
		wait_results_drained();
	endtask

	task automatic test_config_extremes();
		// Zero origin and zero steps put every pixel at the centre: interior.
		set_view(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_pixel(8'd17, 8'd200);
		wait_results_drained();
		// Largest steps make the coordinate sums wrap.
		set_view(16'h7FFF, 16'h8000, 16'h00FF, 16'h00FF, 16'h0000, 16'h0000);
		send_pixel(8'd0, 8'd0);
		send_pixel(8'd255, 8'd255);
		wait_results_drained();
		set_view(16'h8000, 16'h7FFF, 16'h00FF, 16'h00FF, 16'h0000, 16'h0000);
		send_pixel(8'd255, 8'd0);
		send_pixel(8'd0, 8'd255);
		wait_results_drained();
	endtask

	task automatic test_julia_mode();
		// A real part alone selects Julia mode; the corner pixel escapes at once.
		set_view(16'hE000, 16'hE000, 16'h0020, 16'h0020, 16'h0001, 16'h0000);
		send_pixel(8'd0, 8'd0);
		send_pixel(8'd64, 8'd64);
		wait_results_drained();
		write_reg(fetp_pkg::REG_JULIA_REAL, 16'h0000);
		write_reg(fetp_pkg::REG_JULIA_IMAG, 16'h8000);
		send_pixel(8'd64, 8'd64);
		wait_results_drained();
		write_reg(fetp_pkg::REG_JULIA_REAL, 16'h7FFF);
		write_reg(fetp_pkg::REG_JULIA_IMAG, 16'h7FFF);
		send_pixel(8'd64, 8'd64);
		wait_results_drained();
	endtask

	task automatic test_register_decode();
		set_view(16'hE400, 16'hF202, 16'h0033, 16'h0024, 16'h0000, 16'h0000);
		write_reg(REG_UNUSED_A, 16'hFFFF);
		write_reg(REG_UNUSED_B, 16'h1234);
		send_pixel(8'd90, 8'd120);
		wait_results_drained();
		// Only the low byte of a step write is kept.
		write_reg(fetp_pkg::REG_REAL_STEP, 16'hAB10);
		write_reg(fetp_pkg::REG_IMAG_STEP, 16'h54FF);
		send_pixel(8'd200, 8'd3);
		wait_results_drained();
	endtask

	task automatic test_random_mandelbrot();
		int view;
		int k;
		for (view = 0; view < 4; view++) begin
			set_view(16'($urandom_range(0, 8192) - 10240), 16'($urandom_range(0, 5120) - 6144),
				16'($urandom_range(8, 64)), 16'($urandom_range(8, 40)), 16'h0000, 16'h0000);
			// One view runs with no idling on either side.
			tx_gap_max   = (view == 1) ? 0 : $urandom_range(1, 10);
			rx_stall_max = (view == 1) ? 0 : 1;
			for (k = 0; k < 65; k++) begin
				if ($urandom_range(0, 3) != 0)
					send_pixel(8'($urandom_range(0, 159)), 8'($urandom_range(0, 199)));
				else
					send_pixel(8'($urandom), 8'($urandom));
			end
			wait_results_drained();
		end
	endtask

	task automatic test_random_julia();
		int view;
		int k;
		logic [15:0] j_imag;
		tx_gap_max   = 6;
		rx_stall_max = 1;
		for (view = 0; view < 4; view++) begin
			j_imag = 16'($urandom_range(0, 6000) - 3000);
			if (j_imag == 16'h0000)
				j_imag = 16'h0001;
			set_view(16'($urandom_range(0, 2048) - 7168), 16'($urandom_range(0, 2048) - 6144),
				16'($urandom_range(16, 64)), 16'($urandom_range(16, 64)),
				16'($urandom_range(0, 5000) - 3500), j_imag);
			for (k = 0; k < 55; k++)
				send_pixel(8'($urandom_range(0, 159)), 8'($urandom_range(0, 199)));
			wait_results_drained();
		end
	endtask

	task automatic test_random_any();
		int view;
		int k;
		for (view = 0; view < 6; view++) begin
			if (view == 0)
				set_view(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'h0000, 16'h0000);
			else
				set_view(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			tx_gap_max   = $urandom_range(0, 4);
			rx_stall_max = $urandom_range(0, 1);
			for (k = 0; k < 20; k++)
				send_pixel(8'($urandom), 8'($urandom));
			wait_results_drained();
		end
	endtask

	initial begin
		pixel_view.real_origin = fetp_pkg::RST_REAL_ORIGIN;
		pixel_view.imag_origin = fetp_pkg::RST_IMAG_ORIGIN;
		pixel_view.real_step   = fetp_pkg::RST_REAL_STEP;
		pixel_view.imag_step   = fetp_pkg::RST_IMAG_STEP;
		pixel_view.julia_real  = fetp_pkg::RST_JULIA_REAL;
		pixel_view.julia_imag  = fetp_pkg::RST_JULIA_IMAG;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_view();
		test_config_extremes();
		test_julia_mode();
		test_register_decode();
		test_random_mandelbrot();
		test_random_julia();
		test_random_any();

		wait_results_drained();
		repeat (MAX_ITER + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
